// ===== hw/rtl/fra_pkg.sv =====
// Shared constants and types for the frame reference-count allocator.
// Holds sizing constants, operation codes and status codes.
// No dependencies.
package fra_pkg;

	localparam int unsigned FRAME_COUNT     = 4096;
	localparam int unsigned RESERVED_FRAMES = 256;

	localparam int unsigned FRAME_W      = 12;
	localparam int unsigned COUNT_W      = 8;
	localparam int unsigned ADDR_SPAN    = 1 << FRAME_W;
	localparam int unsigned SEARCH_LIMIT = (FRAME_COUNT < ADDR_SPAN) ? FRAME_COUNT : ADDR_SPAN;
	localparam int unsigned MEM_AW       = $clog2(SEARCH_LIMIT);
	localparam int unsigned SCAN_W       = MEM_AW + 1;
	localparam int unsigned RES_CLAMP    =
		(RESERVED_FRAMES < SEARCH_LIMIT) ? RESERVED_FRAMES : SEARCH_LIMIT;

	localparam logic [FRAME_W:0] FRAME_LIMIT_X = SEARCH_LIMIT[FRAME_W:0];
	localparam logic [FRAME_W:0] RESERVED_X    = RESERVED_FRAMES[FRAME_W:0];
	localparam logic [SCAN_W-1:0] LIMIT_S      = SEARCH_LIMIT[SCAN_W-1:0];
	localparam logic [SCAN_W-1:0] RES_CLAMP_S  = RES_CLAMP[SCAN_W-1:0];

	localparam logic [COUNT_W-1:0] KERNEL_COUNT = COUNT_W'(100);
	localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
	localparam logic [COUNT_W-1:0] COUNT_ONE    = COUNT_W'(1);

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_RETAIN  = 2'd2,
		OP_COW     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_NOFREE = 3'd1,
		ST_BAD    = 3'd2,
		ST_FREE   = 3'd3,
		ST_SAT    = 3'd4,
		ST_SOLE   = 3'd5
	} status_t;

endpackage

// ===== hw/rtl/frame_refcount_allocator_top.sv =====
// Frame reference-count allocator: one count per frame in a RAM, one sequencer.
// Depends on fra_pkg and fra_ram.
//
// Usage:
//   Input channel (in_valid/in_stall) carries operation and frame. Output
//   channel (out_valid/out_stall) returns status, result_frame and ref_count,
//   exactly one result transaction per input transaction.
//   One transaction is in work at a time; in_stall stays high until it has
//   been placed in the output register, which may still be waiting while the
//   next transaction is accepted.
//   Sequence: release and retain pass an evaluate state, then the result
//   state; an out-of-range frame goes straight to result. Alloc, and cow_write
//   on a count above one, scan counts from a lowest-free hint, one per cycle
//   through the RAM read port; cow_write then writes its frame's count less one.
//   Reset: after arst_n is released, a clearing pass writes the reset counts
//   (100 for reserved frames, 0 otherwise) into all 4096 entries, one per
//   cycle; in_stall is high until the pass is done.
//   When the receiver stalls, the result holds in the output register and a
//   finished transaction waits in the sequencer until the register frees.
module frame_refcount_allocator_top
	import fra_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [FRAME_W-1:0] frame,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [FRAME_W-1:0] result_frame,
	output logic [COUNT_W-1:0] ref_count
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EVAL,
		S_SCAN,
		S_COW_WR,
		S_RESULT
	} state_t;

	state_t             state_q;
	logic [SCAN_W-1:0]  clr_q;
	logic [SCAN_W-1:0]  lo_q;
	logic [SCAN_W-1:0]  scan_q;
	logic               chk_v_s1;
	logic [MEM_AW-1:0]  chk_addr_s1;
	op_t                op_q;
	logic [FRAME_W-1:0] fr_q;
	logic [COUNT_W-1:0] cnt_q;
	status_t            res_status_q;
	logic [FRAME_W-1:0] res_frame_q;
	logic [COUNT_W-1:0] res_cnt_q;
	logic               out_valid_q;
	logic [2:0]         status_q;
	logic [FRAME_W-1:0] result_frame_q;
	logic [COUNT_W-1:0] ref_count_q;

	logic               wr_en;
	logic [MEM_AW-1:0]  wr_addr;
	logic [COUNT_W-1:0] wr_data;
	logic [MEM_AW-1:0]  rd_addr;
	logic [COUNT_W-1:0] rd_data;
	logic [MEM_AW-1:0]  fr_addr;
	logic               issue_en;
	logic               found;
	logic               exhausted;
	logic               in_accept;
	logic               out_free;

	assign fr_addr   = fr_q[MEM_AW-1:0];
	assign issue_en  = (scan_q != LIMIT_S);
	assign found     = (state_q == S_SCAN) && chk_v_s1 && (rd_data == '0);
	assign exhausted = (state_q == S_SCAN) && !issue_en && !chk_v_s1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign rd_addr   = (state_q == S_IDLE) ? frame[MEM_AW-1:0] : scan_q[MEM_AW-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fr_addr;
		wr_data = '0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q[MEM_AW-1:0];
				wr_data = (clr_q < RES_CLAMP_S) ? KERNEL_COUNT : '0;
			end
			S_EVAL: begin
				if (op_q == OP_RELEASE && {1'b0, fr_q} >= RESERVED_X && rd_data != '0) begin
					wr_en   = 1'b1;
					wr_data = rd_data - COUNT_ONE;
				end else if (op_q == OP_RETAIN && rd_data != COUNT_MAX) begin
					wr_en   = 1'b1;
					wr_data = rd_data + COUNT_ONE;
				end
			end
			S_SCAN: begin
				if (found) begin
					wr_en   = 1'b1;
					wr_addr = chk_addr_s1;
					wr_data = COUNT_ONE;
				end
			end
			S_COW_WR: begin
				wr_en   = 1'b1;
				wr_data = cnt_q - COUNT_ONE;
			end
			S_IDLE, S_RESULT: begin
				wr_en = 1'b0;
			end
		endcase
	end

	fra_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(SEARCH_LIMIT)
	) u_counts (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			lo_q        <= RES_CLAMP_S;
			scan_q      <= '0;
			chk_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_RESULT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SCAN_W'(1);
					if (clr_q == LIMIT_S - SCAN_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						op_q     <= op_t'(operation);
						fr_q     <= frame;
						scan_q   <= lo_q;
						chk_v_s1 <= 1'b0;
						if (op_t'(operation) == OP_ALLOC) begin
							state_q <= S_SCAN;
						end else if ({1'b0, frame} >= FRAME_LIMIT_X) begin
							res_status_q <= ST_BAD;
							res_frame_q  <= frame;
							res_cnt_q    <= '0;
							state_q      <= S_RESULT;
						end else begin
							state_q <= S_EVAL;
						end
					end
				end
				S_EVAL: begin
					cnt_q        <= rd_data;
					res_frame_q  <= fr_q;
					res_cnt_q    <= rd_data;
					res_status_q <= ST_OK;
					state_q      <= S_RESULT;
					unique case (op_q)
						OP_RELEASE: begin
							if ({1'b0, fr_q} < RESERVED_X) begin
								res_status_q <= ST_BAD;
							end else if (rd_data == '0) begin
								res_status_q <= ST_FREE;
							end else begin
								res_cnt_q <= rd_data - COUNT_ONE;
								if (rd_data == COUNT_ONE && {1'b0, fr_addr} < lo_q) begin
									lo_q <= {1'b0, fr_addr};
								end
							end
						end
						OP_RETAIN: begin
							if (rd_data == COUNT_MAX) begin
								res_status_q <= ST_SAT;
							end else begin
								res_cnt_q <= rd_data + COUNT_ONE;
							end
						end
						OP_COW: begin
							if (rd_data == '0) begin
								res_status_q <= ST_FREE;
							end else if (rd_data == COUNT_ONE) begin
								res_status_q <= ST_SOLE;
							end else begin
								scan_q   <= lo_q;
								chk_v_s1 <= 1'b0;
								state_q  <= S_SCAN;
							end
						end
						OP_ALLOC: begin
							res_status_q <= ST_BAD;
						end
					endcase
				end
				S_SCAN: begin
					if (issue_en) begin
						scan_q <= scan_q + SCAN_W'(1);
					end
					chk_v_s1    <= issue_en;
					chk_addr_s1 <= scan_q[MEM_AW-1:0];
					if (found) begin
						lo_q         <= {1'b0, chk_addr_s1} + SCAN_W'(1);
						res_status_q <= ST_OK;
						res_frame_q  <= FRAME_W'(chk_addr_s1);
						if (op_q == OP_ALLOC) begin
							res_cnt_q <= COUNT_ONE;
							state_q   <= S_RESULT;
						end else begin
							res_cnt_q <= cnt_q - COUNT_ONE;
							state_q   <= S_COW_WR;
						end
					end else if (exhausted) begin
						lo_q         <= LIMIT_S;
						res_status_q <= ST_NOFREE;
						state_q      <= S_RESULT;
						if (op_q == OP_ALLOC) begin
							res_frame_q <= '0;
							res_cnt_q   <= '0;
						end else begin
							res_frame_q <= fr_q;
							res_cnt_q   <= cnt_q;
						end
					end
				end
				S_COW_WR: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						status_q       <= res_status_q;
						result_frame_q <= res_frame_q;
						ref_count_q    <= res_cnt_q;
						state_q        <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_frame = result_frame_q;
	assign ref_count    = ref_count_q;

`ifndef SYNTHESIS
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> in_stall)
		else $error("input accepted while a transaction is in work");

	a_hint_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		lo_q <= LIMIT_S)
		else $error("free-frame hint beyond search limit");

	a_no_write_while_scanning: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && !found) |-> !wr_en)
		else $error("count RAM written during scan");

	a_result_from_sequencer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_RESULT)
		else $error("result raised outside result state");
`endif

endmodule

// ===== hw/rtl/fra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fra_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
